### rtl/subspace_distance_classifier_top_assert.svh
// assertion macros shared by the rtl
`ifndef SUBSPACE_DISTANCE_CLASSIFIER_TOP_ASSERT_SVH
`define SUBSPACE_DISTANCE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define SDC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sdc_pkg.sv
package sdc_pkg;

    localparam int DEF_MAX_CLASSES    = 16;
    localparam int DEF_MAX_FEATURES   = 8;
    localparam int DEF_MAX_COMPONENTS = 8;

    localparam int VALUE_W    = 32;
    localparam int CC_W       = 5;
    localparam int FC_W       = 4;
    localparam int UC_W       = 4;
    localparam int CFG_BITS   = CC_W + FC_W + UC_W;
    localparam int CFG_DATA_W = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CC_W-1:0] CLASS_COUNT_RST = 5'd11;
    localparam logic [FC_W-1:0] FEAT_COUNT_RST  = 4'd8;
    localparam logic [UC_W-1:0] COMP_COUNT_RST  = 4'd6;

    localparam logic [63:0] DIST_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BOUND_DIST = 64'd100000000 << 32;

    typedef enum logic [1:0] {
        CFG_CLASS_COUNT = 2'd0,
        CFG_FEAT_COUNT  = 2'd1,
        CFG_COMP_COUNT  = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_MEAN    = 2'd0,
        ACT_EIGVEC  = 2'd1,
        ACT_EIGVAL  = 2'd2,
        ACT_FEATURE = 2'd3
    } action_t;

    typedef struct packed {
        logic                en;
        action_t             action;
        logic [3:0]          cls;
        logic [2:0]          comp;
        logic [2:0]          elem;
        logic [VALUE_W-1:0]  value;
    } tbl_wr_t;

    typedef enum logic [3:0] {
        B_IDLE, B_CLASS, B_COMP, B_ADDR, B_DATA, B_MUL, B_ACC,
        B_MAG, B_SQR, B_LAM, B_DIV, B_ADD, B_CMP, B_OUT
    } back_state_t;

endpackage

### rtl/sdc_queue.sv
module sdc_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= bump(wp_reg);
            end
            if (pop)
            begin
                rp_reg <= bump(rp_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

### rtl/sdc_front.sv
module sdc_front #(
    parameter int MAX_FEATURES = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [3:0]                class_index,
    input  logic [2:0]                component_index,
    input  logic [2:0]                element_index,
    input  logic signed [31:0]        value,
    input  logic                      last,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                      back_busy,
    input  logic                      q_empty,
    input  logic                      q_full,
    output sdc_pkg::tbl_wr_t          tbl_wr,
    output logic                      q_push,
    output logic [MAX_FEATURES*sdc_pkg::VALUE_W+sdc_pkg::CFG_BITS-1:0] q_wdata
);
    import sdc_pkg::*;

    logic [VALUE_W-1:0] feat_reg  [MAX_FEATURES];
    logic [VALUE_W-1:0] feat_next [MAX_FEATURES];
    logic [CC_W-1:0]    class_cnt_reg;
    logic [FC_W-1:0]    feat_cnt_reg;
    logic [UC_W-1:0]    comp_cnt_reg;
    logic               is_feat, accept;

    assign is_feat  = (action == ACT_FEATURE);
    // table loads wait until no classification is pending
    assign in_stall = is_feat ? (last && q_full) : (back_busy || !q_empty);
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && is_feat && last;

    always_comb
    begin
        tbl_wr.en     = accept && !is_feat;
        tbl_wr.action = action_t'(action);
        tbl_wr.cls    = class_index;
        tbl_wr.comp   = component_index;
        tbl_wr.elem   = element_index;
        tbl_wr.value  = value;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_FEATURES; k++)
        begin
            feat_next[k] = feat_reg[k];
            if (accept && is_feat && (32'(element_index) == k))
            begin
                feat_next[k] = value;
            end
            q_wdata[k*VALUE_W +: VALUE_W] = feat_next[k];
        end
        q_wdata[MAX_FEATURES*VALUE_W +: CFG_BITS] = {class_cnt_reg, feat_cnt_reg, comp_cnt_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_FEATURES; k++)
        begin
            feat_reg[k] <= feat_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_cnt_reg <= CLASS_COUNT_RST;
            feat_cnt_reg  <= FEAT_COUNT_RST;
            comp_cnt_reg  <= COMP_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLASS_COUNT: class_cnt_reg <= cfg_data[CC_W-1:0];
                CFG_FEAT_COUNT:  feat_cnt_reg  <= cfg_data[FC_W-1:0];
                CFG_COMP_COUNT:  comp_cnt_reg  <= cfg_data[UC_W-1:0];
                default: ;
            endcase
        end
    end
endmodule

### rtl/sdc_back.sv
module sdc_back #(
    parameter int MAX_CLASSES    = 16,
    parameter int MAX_FEATURES   = 8,
    parameter int MAX_COMPONENTS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdc_pkg::tbl_wr_t     tbl_wr,
    input  logic                 q_empty,
    input  logic [MAX_FEATURES*sdc_pkg::VALUE_W+sdc_pkg::CFG_BITS-1:0] q_rdata,
    output logic                 q_pop,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           best_class,
    output logic [62:0]          best_distance
);
    import sdc_pkg::*;

    localparam int MEAN_D = MAX_CLASSES * MAX_FEATURES;
    localparam int LAM_D  = MAX_CLASSES * MAX_COMPONENTS;
    localparam int EV_D   = LAM_D * MAX_FEATURES;
    localparam int MEAN_AW = (MEAN_D > 1) ? $clog2(MEAN_D) : 1;
    localparam int LAM_AW  = (LAM_D > 1) ? $clog2(LAM_D) : 1;
    localparam int EV_AW   = (EV_D > 1) ? $clog2(EV_D) : 1;
    localparam int NC_W = $clog2(MAX_CLASSES + 1);
    localparam int NF_W = $clog2(MAX_FEATURES + 1);
    localparam int NU_W = $clog2(MAX_COMPONENTS + 1);
    localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW   = 48 + $clog2(MAX_FEATURES + 1) + 1;

    logic [VALUE_W-1:0] mean_mem [MEAN_D];
    logic [VALUE_W-1:0] ev_mem   [EV_D];
    logic [VALUE_W-1:0] lam_mem  [LAM_D];
    logic [VALUE_W-1:0] mean_rd, ev_rd, lam_rd;

    back_state_t state_reg, state_next;

    logic [VALUE_W-1:0] feat_reg [MAX_FEATURES];
    logic [NC_W-1:0] nc_reg, i_reg;
    logic [NF_W-1:0] nf_reg, z_reg;
    logic [NU_W-1:0] nu_reg, j_reg;
    logic signed [31:0] d_reg, e_reg;
    logic signed [63:0] prod_reg;
    logic signed [PW-1:0] proj_reg;
    logic [31:0] mag_reg, rem_reg;
    logic [63:0] sq_reg, q_reg, term_reg, sum_reg, best_reg;
    logic [78:0] div_sh_reg;
    logic [6:0]  div_cnt_reg;
    logic [NC_W-1:0] choice_reg;
    logic        out_valid_reg;
    logic [3:0]  out_class_reg;
    logic [62:0] out_dist_reg;

    logic [CC_W-1:0] raw_nc;
    logic [FC_W-1:0] raw_nf;
    logic [UC_W-1:0] raw_nu;
    logic [MEAN_AW-1:0] mean_wa, mean_ra;
    logic [EV_AW-1:0]   ev_wa, ev_ra;
    logic [LAM_AW-1:0]  lam_wa, lam_ra;
    logic cls_ok, comp_ok, elem_ok;
    logic signed [32:0] diff_w;
    logic signed [PW-1:0] proj_sat;
    logic [31:0] r_shift;
    logic [63:0] q_shift, add_w;
    logic last_i, last_j, last_z, out_free;

    // table writes
    assign cls_ok  = 32'(tbl_wr.cls) < MAX_CLASSES;
    assign comp_ok = 32'(tbl_wr.comp) < MAX_COMPONENTS;
    assign elem_ok = 32'(tbl_wr.elem) < MAX_FEATURES;
    assign mean_wa = MEAN_AW'(32'(tbl_wr.cls) * MAX_FEATURES + 32'(tbl_wr.elem));
    assign lam_wa  = LAM_AW'(32'(tbl_wr.cls) * MAX_COMPONENTS + 32'(tbl_wr.comp));
    assign ev_wa   = EV_AW'((32'(tbl_wr.cls) * MAX_COMPONENTS + 32'(tbl_wr.comp))
                            * MAX_FEATURES + 32'(tbl_wr.elem));

    assign mean_ra = MEAN_AW'(32'(i_reg) * MAX_FEATURES + 32'(z_reg));
    assign lam_ra  = LAM_AW'(32'(i_reg) * MAX_COMPONENTS + 32'(j_reg));
    assign ev_ra   = EV_AW'((32'(i_reg) * MAX_COMPONENTS + 32'(j_reg)) * MAX_FEATURES
                            + 32'(z_reg));

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en && tbl_wr.action == ACT_MEAN && cls_ok && elem_ok)
        begin
            mean_mem[mean_wa] <= tbl_wr.value;
        end
        if (tbl_wr.en && tbl_wr.action == ACT_EIGVEC && cls_ok && comp_ok && elem_ok)
        begin
            ev_mem[ev_wa] <= tbl_wr.value;
        end
        if (tbl_wr.en && tbl_wr.action == ACT_EIGVAL && cls_ok && comp_ok)
        begin
            lam_mem[lam_wa] <= tbl_wr.value;
        end
        if (state_reg == B_ADDR)
        begin
            mean_rd <= mean_mem[mean_ra];
            ev_rd   <= ev_mem[ev_ra];
        end
        if (state_reg == B_COMP)
        begin
            lam_rd <= lam_mem[lam_ra];
        end
    end

    assign {raw_nc, raw_nf, raw_nu} = q_rdata[MAX_FEATURES*VALUE_W +: CFG_BITS];

    assign last_i   = (32'(i_reg) + 1 == 32'(nc_reg));
    assign last_j   = (32'(j_reg) + 1 == 32'(nu_reg));
    assign last_z   = (32'(z_reg) + 1 == 32'(nf_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign busy     = (state_reg != B_IDLE);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    assign diff_w = 33'(signed'(feat_reg[z_reg[FI_W-1:0]])) - 33'(signed'(mean_rd));

    always_comb
    begin
        if (proj_reg > signed'(PW'(32'h7FFF_FFFF)))
        begin
            proj_sat = signed'(PW'(32'h7FFF_FFFF));
        end
        else if (proj_reg < -signed'(PW'(33'h1_0000_0000 >> 1)))
        begin
            proj_sat = -signed'(PW'(33'h1_0000_0000 >> 1));
        end
        else
        begin
            proj_sat = proj_reg;
        end
    end

    assign r_shift = {rem_reg[30:0], div_sh_reg[78]};
    assign q_shift = {q_reg[62:0], 1'b0};
    assign add_w   = sum_reg + term_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_CLASS;
            B_CLASS: state_next = B_COMP;
            B_COMP:  state_next = B_ADDR;
            B_ADDR:  state_next = B_DATA;
            B_DATA:  state_next = B_MUL;
            B_MUL:   state_next = B_ACC;
            B_ACC:   state_next = last_z ? B_MAG : B_ADDR;
            B_MAG:   state_next = B_SQR;
            B_SQR:   state_next = B_LAM;
            B_LAM:   state_next = (signed'(lam_rd) <= 0) ? B_ADD : B_DIV;
            B_DIV:
                if (q_reg[63:62] != 2'b00 || div_cnt_reg == '0)
                begin
                    state_next = B_ADD;
                end
            B_ADD:   state_next = last_j ? B_CMP : B_COMP;
            B_CMP:   state_next = last_i ? B_OUT : B_CLASS;
            B_OUT:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    for (int k = 0; k < MAX_FEATURES; k++)
                    begin
                        feat_reg[k] <= q_rdata[k*VALUE_W +: VALUE_W];
                    end
                    nc_reg <= (raw_nc == '0) ? NC_W'(1) :
                              (32'(raw_nc) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(raw_nc);
                    nf_reg <= (raw_nf == '0) ? NF_W'(1) :
                              (32'(raw_nf) > MAX_FEATURES) ? NF_W'(MAX_FEATURES) : NF_W'(raw_nf);
                    nu_reg <= (raw_nu == '0) ? NU_W'(1) :
                              (32'(raw_nu) > MAX_COMPONENTS) ? NU_W'(MAX_COMPONENTS)
                                                             : NU_W'(raw_nu);
                    i_reg      <= '0;
                    best_reg   <= BOUND_DIST;
                    choice_reg <= '0;
                end
            B_CLASS:
            begin
                sum_reg <= '0;
                j_reg   <= '0;
            end
            B_COMP:
            begin
                proj_reg <= '0;
                z_reg    <= '0;
            end
            B_DATA:
            begin
                // feature minus mean, saturated to 32 bits
                if (diff_w > 33'sd2147483647)
                begin
                    d_reg <= 32'sh7FFF_FFFF;
                end
                else if (diff_w < -33'sd2147483648)
                begin
                    d_reg <= 32'sh8000_0000;
                end
                else
                begin
                    d_reg <= diff_w[31:0];
                end
                e_reg <= ev_rd;
            end
            B_MUL: prod_reg <= d_reg * e_reg;
            B_ACC:
            begin
                // arithmetic shift floors toward minus infinity
                proj_reg <= proj_reg + PW'(prod_reg >>> 16);
                z_reg    <= z_reg + 1'b1;
            end
            B_MAG:   mag_reg <= proj_sat[PW-1] ? 32'(-proj_sat) : 32'(proj_sat);
            B_SQR:   sq_reg <= 64'(mag_reg) * 64'(mag_reg);
            B_LAM:
            begin
                term_reg    <= DIST_MAX;
                div_sh_reg  <= {sq_reg[62:0], 16'b0};
                rem_reg     <= '0;
                q_reg       <= '0;
                div_cnt_reg <= 7'd78;
            end
            B_DIV:
            begin
                if (q_reg[63:62] != 2'b00)
                begin
                    term_reg <= DIST_MAX;
                end
                else
                begin
                    div_sh_reg  <= {div_sh_reg[77:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (r_shift >= lam_rd)
                    begin
                        rem_reg <= r_shift - lam_rd;
                        q_reg   <= q_shift | 64'd1;
                        term_reg <= q_shift | 64'd1;
                    end
                    else
                    begin
                        rem_reg  <= r_shift;
                        q_reg    <= q_shift;
                        term_reg <= q_shift;
                    end
                end
            end
            B_ADD:
            begin
                sum_reg <= (add_w > DIST_MAX) ? DIST_MAX : add_w;
                j_reg   <= j_reg + 1'b1;
            end
            B_CMP:
            begin
                if (sum_reg < best_reg)
                begin
                    best_reg   <= sum_reg;
                    choice_reg <= i_reg;
                end
                i_reg <= i_reg + 1'b1;
            end
            B_OUT:
                if (out_free)
                begin
                    out_class_reg <= 4'(choice_reg);
                    out_dist_reg  <= best_reg[62:0];
                end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign best_class    = out_class_reg;
    assign best_distance = out_dist_reg;
endmodule

### rtl/subspace_distance_classifier_top.sv
// nearest-class classifier over per-class eigen subspaces. table loads (mean,
// eigenvector element, eigenvalue) and feature elements each take one beat and
// are accepted when not stalled; a feature beat marked last queues a
// classification job and yields one result beat. a job is worked through
// serially by a 32x32 multiplier, a squaring multiplier, the one-read-port
// table memories and the 79-step bit-serial divider; a component with a
// non-positive eigenvalue or an overflowing quotient finishes early. table
// loads stall while a job is queued or running; feature beats keep flowing,
// and only a last beat stalls while the two-entry job queue is full.
`include "subspace_distance_classifier_top_assert.svh"

module subspace_distance_classifier_top #(
    parameter int MAX_CLASSES    = sdc_pkg::DEF_MAX_CLASSES,
    parameter int MAX_FEATURES   = sdc_pkg::DEF_MAX_FEATURES,
    parameter int MAX_COMPONENTS = sdc_pkg::DEF_MAX_COMPONENTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [3:0]         class_index,
    input  logic [2:0]         component_index,
    input  logic [2:0]         element_index,
    input  logic signed [31:0] value,
    input  logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         best_class,
    output logic [62:0]        best_distance
);
    import sdc_pkg::*;

    // job word: raw counts above the feature snapshot
    localparam int JOB_W = MAX_FEATURES * VALUE_W + CFG_BITS;

    tbl_wr_t           tbl_wr;
    logic              q_push, q_pop, q_empty, q_full, back_busy;
    logic [JOB_W-1:0]  q_wdata, q_rdata;

    // front: handshake, config registers, feature buffer
    sdc_front #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .class_index(class_index),
        .component_index(component_index), .element_index(element_index),
        .value(value), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .back_busy(back_busy), .q_empty(q_empty), .q_full(q_full),
        .tbl_wr(tbl_wr), .q_push(q_push), .q_wdata(q_wdata)
    );

    // job queue between the two sides
    sdc_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wdata(q_wdata),
        .pop(q_pop), .rdata(q_rdata),
        .empty(q_empty), .full(q_full)
    );

    // back: tables, distance sequencer, result register
    sdc_back #(
        .MAX_CLASSES(MAX_CLASSES),
        .MAX_FEATURES(MAX_FEATURES),
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .tbl_wr(tbl_wr),
        .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop),
        .busy(back_busy),
        .out_valid(out_valid), .out_stall(out_stall),
        .best_class(best_class), .best_distance(best_distance)
    );

    // tables only change with no job in flight
    `SDC_ASSERT_NOW(a_tbl_quiet, clk, rst_n, tbl_wr.en, !back_busy && q_empty,
        "table write during a pending classification")
    // no push into a full queue
    `SDC_ASSERT_NOW(a_q_no_ovf, clk, rst_n, q_push, !q_full, "job queue overflow")
    // a pushed job is visible next cycle
    `SDC_ASSERT_NEXT(a_q_holds, clk, rst_n, q_push, !q_empty, "pushed job lost")
    // result never above the starting bound
    `SDC_ASSERT_NOW(a_dist_bound, clk, rst_n, out_valid,
        best_distance <= BOUND_DIST[62:0], "result above bound")
endmodule
